// ===== hw/rtl/eputc_pkg.sv =====
// ----------------------------------------------------------------------------
// eputc_pkg: shared types and constants of the epoch-to-UTC converter
// Pipeline depth, stage split, result structs and the month offset table.
// ----------------------------------------------------------------------------
package eputc_pkg;

	// total pipeline depth and depth of the seconds/days split front end
	localparam int NST      = 14;
	localparam int FRONT_ST = 3;

	// seconds within the day: 0..86399
	localparam int SOD_W = 17;

	// packed result width and the byte-padded stream width
	localparam int OUT_W       = 51;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// month codes, 0 is January
	localparam logic [3:0] MON_JAN = 4'd0;
	localparam logic [3:0] MON_FEB = 4'd1;
	localparam logic [3:0] MON_MAR = 4'd2;
	localparam logic [3:0] MON_APR = 4'd3;
	localparam logic [3:0] MON_MAY = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd5;
	localparam logic [3:0] MON_JUL = 4'd6;
	localparam logic [3:0] MON_AUG = 4'd7;
	localparam logic [3:0] MON_SEP = 4'd8;
	localparam logic [3:0] MON_OCT = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd10;
	localparam logic [3:0] MON_DEC = 4'd11;

	// time of day
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	// calendar date
	typedef struct packed {
		logic [4:0]  mday;
		logic [3:0]  month;
		logic [11:0] years;
		logic [2:0]  wday;
		logic [8:0]  yday;
		logic        dst;
	} date_t;

	// first day of each month of a March-based year, counted from March 1st
	function automatic logic [8:0] mar_month_ofs(input logic [3:0] mp);
		logic [8:0] ofs;
		case (mp)
			4'd0:    ofs = 9'd0;
			4'd1:    ofs = 9'd31;
			4'd2:    ofs = 9'd61;
			4'd3:    ofs = 9'd92;
			4'd4:    ofs = 9'd122;
			4'd5:    ofs = 9'd153;
			4'd6:    ofs = 9'd184;
			4'd7:    ofs = 9'd214;
			4'd8:    ofs = 9'd245;
			4'd9:    ofs = 9'd275;
			4'd10:   ofs = 9'd306;
			4'd11:   ofs = 9'd337;
			default: ofs = 9'd0;
		endcase
		return ofs;
	endfunction

endpackage

// ===== hw/rtl/eputc_daysplit.sv =====
// ----------------------------------------------------------------------------
// eputc_daysplit: seconds count to whole days and seconds of the day
// Three stages: reciprocal multiply, remainder, one-step correction.
// ----------------------------------------------------------------------------
module eputc_daysplit #(
	parameter int SECONDS_WIDTH = 36
) (
	input  logic                            clk,
	input  logic [eputc_pkg::FRONT_ST:1]    en,
	input  logic [SECONDS_WIDTH-1:0]        epoch_seconds,
	output logic [SECONDS_WIDTH-17:0]       days,
	output logic [eputc_pkg::SOD_W-1:0]     sod
);
	import eputc_pkg::*;

	// 86400 = 128 * 675: drop 7 bits, then divide by 675
	localparam int NW = SECONDS_WIDTH - 7;
	localparam int DW = SECONDS_WIDTH - 16;
	localparam int PW = NW + DW;
	localparam longint unsigned RECIP = (64'd1 << NW) / 675;

	logic [PW-1:0]   prod_s1;
	logic [10:0]     nlo_s1;
	logic [6:0]      lo_s1;
	logic [DW-1:0]   q_s2;
	logic [10:0]     r0_s2;
	logic [6:0]      lo_s2;
	logic [DW-1:0]   days_s3;
	logic [SOD_W-1:0] sod_s3;

	logic [NW-1:0]   n;
	logic [DW-1:0]   q0;
	logic            ge;
	logic [10:0]     rc;

	assign n  = epoch_seconds[SECONDS_WIDTH-1:7];
	assign q0 = prod_s1[PW-1:NW];
	assign ge = (r0_s2 >= 11'd675);
	assign rc = ge ? (r0_s2 - 11'd675) : r0_s2;

	// stage 1: floor reciprocal, quotient low by at most one
	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s1 <= PW'(n) * PW'(RECIP);
			nlo_s1  <= n[10:0];
			lo_s1   <= epoch_seconds[6:0];
		end
	end

	// stage 2: remainder below 1350, so 11 low bits are exact
	always_ff @(posedge clk) begin
		if (en[2]) begin
			q_s2  <= q0;
			r0_s2 <= nlo_s1 - 11'(22'(q0[10:0]) * 22'd675);
			lo_s2 <= lo_s1;
		end
	end

	// stage 3: fix quotient, rebuild seconds of the day
	always_ff @(posedge clk) begin
		if (en[3]) begin
			days_s3 <= q_s2 + DW'(ge);
			sod_s3  <= {rc[9:0], lo_s2};
		end
	end

	assign days = days_s3;
	assign sod  = sod_s3;

endmodule

// ===== hw/rtl/eputc_tod.sv =====
// ----------------------------------------------------------------------------
// eputc_tod: seconds of the day to hour, minute and second
// Four compute stages, then a delay line to line up with the date path.
// ----------------------------------------------------------------------------
module eputc_tod (
	input  logic                                          clk,
	input  logic [eputc_pkg::NST:eputc_pkg::FRONT_ST+1]   en,
	input  logic [eputc_pkg::SOD_W-1:0]                   sod,
	output eputc_pkg::hms_t                               hms
);
	import eputc_pkg::*;

	logic [4:0]       hour_s4;
	logic [SOD_W-1:0] sod_s4;
	logic [4:0]       hour_s5;
	logic [11:0]      rem_s5;
	logic [4:0]       hour_s6;
	logic [11:0]      rem_s6;
	logic [5:0]       min_s6;
	hms_t             hms_s [FRONT_ST+4:NST];

	logic [31:0] hprod;
	logic [23:0] mprod;

	// hour = sod / 3600, exact for sod below 86400
	assign hprod = 32'(sod) * 32'd37283;
	// minute = rem / 60, exact for rem below 3600
	assign mprod = 24'(rem_s5) * 24'd4370;

	always_ff @(posedge clk) begin
		if (en[FRONT_ST+1]) begin
			hour_s4 <= hprod[31:27];
			sod_s4  <= sod;
		end
		if (en[FRONT_ST+2]) begin
			hour_s5 <= hour_s4;
			rem_s5  <= 12'(sod_s4 - 17'(17'(hour_s4) * 17'd3600));
		end
		if (en[FRONT_ST+3]) begin
			hour_s6 <= hour_s5;
			rem_s6  <= rem_s5;
			min_s6  <= mprod[23:18];
		end
		if (en[FRONT_ST+4]) begin
			hms_s[FRONT_ST+4].hour   <= hour_s6;
			hms_s[FRONT_ST+4].minute <= min_s6;
			hms_s[FRONT_ST+4].second <= 6'(rem_s6 - 12'(12'(min_s6) * 12'd60));
		end
		// delay line to the output stage
		for (int s = FRONT_ST + 5; s <= NST; s++) begin
			if (en[s]) begin
				hms_s[s] <= hms_s[s-1];
			end
		end
	end

	assign hms = hms_s[NST];

endmodule

// ===== hw/rtl/eputc_civil.sv =====
// ----------------------------------------------------------------------------
// eputc_civil: day count to Gregorian date, weekday and DST flag
// Days are rebased to 0000-03-01 and split into 400-year eras; the year and
// month inside the era come from constant reciprocal multiplies.
// ----------------------------------------------------------------------------
module eputc_civil #(
	parameter int SECONDS_WIDTH = 36
) (
	input  logic                                          clk,
	input  logic [eputc_pkg::NST:eputc_pkg::FRONT_ST+1]   en,
	input  logic [SECONDS_WIDTH-17:0]                     days,
	output eputc_pkg::date_t                              date
);
	import eputc_pkg::*;

	localparam int DW = SECONDS_WIDTH - 16;
	localparam int ZW = ((DW > 20) ? DW : 20) + 1;
	localparam int EW = ZW - 17;
	localparam int YW = EW + 10;
	localparam longint unsigned ERA_RECIP = (64'd1 << ZW) / 146097;
	// days from 0000-03-01 to 1970-01-01
	localparam int unsigned EPOCH_SHIFT = 719468;
	localparam int unsigned ERA_DAYS = 146097;

	localparam int C1 = FRONT_ST + 1;

	// stage registers
	logic [ZW-1:0] z_s4;
	logic [EW-1:0] era_s4;
	logic [18:0]   doe_s5;
	logic [EW-1:0] era_s5;
	logic [17:0]   doe_s6;
	logic [EW-1:0] era_s6;
	logic [17:0]   doe_s7;
	logic [EW-1:0] era_s7;
	logic [6:0]    q1460_s7;
	logic [1:0]    c3_s7;
	logic [5:0]    wsum_s7;
	logic [17:0]   x_s8;
	logic [17:0]   doe_s8;
	logic [EW-1:0] era_s8;
	logic [2:0]    wday_s8;
	logic [8:0]    yoe_s9;
	logic [17:0]   doe_s9;
	logic [EW-1:0] era_s9;
	logic [2:0]    wday_s9;
	logic [17:0]   dby_s10;
	logic [8:0]    yoe_s10;
	logic [17:0]   doe_s10;
	logic [EW-1:0] era_s10;
	logic [2:0]    wday_s10;
	logic [8:0]    doy_s11;
	logic [8:0]    yoe_s11;
	logic [EW-1:0] era_s11;
	logic [2:0]    wday_s11;
	logic [3:0]    mp_s12;
	logic [8:0]    doy_s12;
	logic [8:0]    yoe_s12;
	logic [EW-1:0] era_s12;
	logic [2:0]    wday_s12;
	logic [4:0]    mday_s13;
	logic [3:0]    month_s13;
	logic [8:0]    yc_s13;
	logic          jf_s13;
	logic [8:0]    doy_s13;
	logic [EW-1:0] era_s13;
	logic [2:0]    wday_s13;
	date_t         date_s14;

	// combinational terms
	logic [ZW-1:0]    z;
	logic [ZW+EW-1:0] eprod;
	logic             ege;
	logic [35:0]      p1460;
	logic [20:0]      wv;
	logic [5:0]       wsum;
	logic [3:0]       wfold;
	logic [35:0]      p365;
	logic [20:0]      p100;
	logic [10:0]      mv;
	logic [21:0]      pmp;
	logic             leap;
	logic [5:0]       wd8;
	logic             dst;

	// stage 1: rebase to March 1st of year 0, estimate the era
	assign z     = ZW'(days) + ZW'(EPOCH_SHIFT);
	assign eprod = (ZW+EW)'(z) * (ZW+EW)'(ERA_RECIP);

	always_ff @(posedge clk) begin
		if (en[C1]) begin
			z_s4   <= z;
			era_s4 <= eprod[ZW+EW-1:ZW];
		end
	end

	// stage 2: day of era, possibly one era too many
	always_ff @(posedge clk) begin
		if (en[C1+1]) begin
			doe_s5 <= 19'(z_s4) - 19'((EW+18)'(era_s4) * (EW+18)'(ERA_DAYS));
			era_s5 <= era_s4;
		end
	end

	// stage 3: correct era
	assign ege = (doe_s5 >= 19'(ERA_DAYS));

	always_ff @(posedge clk) begin
		if (en[C1+2]) begin
			doe_s6 <= ege ? 18'(doe_s5 - 19'(ERA_DAYS)) : doe_s5[17:0];
			era_s6 <= era_s5 + EW'(ege);
		end
	end

	// stage 4: leap corrections; weekday digit sum (8 = 1 mod 7)
	assign p1460 = 36'(doe_s6) * 36'd183861;
	assign wv    = 21'(doe_s6) + 21'd3;

	always_comb begin
		wsum = '0;
		for (int i = 0; i < 7; i++) begin
			wsum = wsum + 6'(wv[3*i +: 3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[C1+3]) begin
			q1460_s7 <= p1460[34:28];
			c3_s7    <= 2'(doe_s6 >= 18'd36524) + 2'(doe_s6 >= 18'd73048)
				+ 2'(doe_s6 >= 18'd109572);
			wsum_s7  <= wsum;
			doe_s7   <= doe_s6;
			era_s7   <= era_s6;
		end
	end

	// stage 5: leap-free day count; weekday final fold
	assign wfold = 4'(wsum_s7[5:3]) + 4'(wsum_s7[2:0]);

	always_ff @(posedge clk) begin
		if (en[C1+4]) begin
			x_s8    <= doe_s7 - 18'(q1460_s7) + 18'(c3_s7);
			wday_s8 <= (wfold >= 4'd7) ? 3'(wfold - 4'd7) : wfold[2:0];
			doe_s8  <= doe_s7;
			era_s8  <= era_s7;
		end
	end

	// stage 6: year of era = x / 365
	assign p365 = 36'(x_s8) * 36'd183860;

	always_ff @(posedge clk) begin
		if (en[C1+5]) begin
			yoe_s9  <= p365[34:26];
			doe_s9  <= doe_s8;
			era_s9  <= era_s8;
			wday_s9 <= wday_s8;
		end
	end

	// stage 7: days before that year within the era
	assign p100 = 21'(yoe_s9) * 21'd41;

	always_ff @(posedge clk) begin
		if (en[C1+6]) begin
			dby_s10  <= 18'(18'(yoe_s9) * 18'd365) + 18'(yoe_s9[8:2]) - 18'(p100[14:12]);
			yoe_s10  <= yoe_s9;
			doe_s10  <= doe_s9;
			era_s10  <= era_s9;
			wday_s10 <= wday_s9;
		end
	end

	// stage 8: day of the March-based year
	always_ff @(posedge clk) begin
		if (en[C1+7]) begin
			doy_s11  <= 9'(doe_s10 - dby_s10);
			yoe_s11  <= yoe_s10;
			era_s11  <= era_s10;
			wday_s11 <= wday_s10;
		end
	end

	// stage 9: March-based month = (5 * doy + 2) / 153
	assign mv  = 11'(11'(doy_s11) * 11'd5) + 11'd2;
	assign pmp = 22'(mv) * 22'd1714;

	always_ff @(posedge clk) begin
		if (en[C1+8]) begin
			mp_s12   <= pmp[21:18];
			doy_s12  <= doy_s11;
			yoe_s12  <= yoe_s11;
			era_s12  <= era_s11;
			wday_s12 <= wday_s11;
		end
	end

	// stage 10: day of month, calendar month, January/February roll
	always_ff @(posedge clk) begin
		if (en[C1+9]) begin
			mday_s13  <= 5'(doy_s12 - mar_month_ofs(mp_s12) + 9'd1);
			month_s13 <= (mp_s12 < 4'd10) ? (mp_s12 + 4'd2) : (mp_s12 - 4'd10);
			yc_s13    <= yoe_s12 + 9'(mp_s12 >= 4'd10);
			jf_s13    <= (mp_s12 >= 4'd10);
			doy_s13   <= doy_s12;
			era_s13   <= era_s12;
			wday_s13  <= wday_s12;
		end
	end

	// stage 11: day of year, year offset, daylight saving
	// era is a multiple of 400 years, so leap depends on the year of era alone
	assign leap = (yc_s13[1:0] == 2'd0) && (yc_s13 != 9'd100) && (yc_s13 != 9'd200)
		&& (yc_s13 != 9'd300);
	assign wd8  = 6'(wday_s13) + 6'd8;

	always_comb begin
		case (month_s13)
			MON_APR, MON_MAY, MON_JUN, MON_JUL, MON_AUG, MON_SEP, MON_OCT: begin
				dst = 1'b1;
			end
			MON_MAR: begin
				// previous Sunday on or after the 8th
				dst = (6'(mday_s13) >= wd8);
			end
			MON_NOV: begin
				// previous Sunday still in October
				dst = (mday_s13 <= 5'(wday_s13));
			end
			default: begin
				dst = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[C1+10]) begin
			date_s14.mday  <= mday_s13;
			date_s14.month <= month_s13;
			date_s14.wday  <= wday_s13;
			date_s14.dst   <= dst;
			date_s14.yday  <= jf_s13 ? (doy_s13 - 9'd306) : (doy_s13 + 9'd59 + 9'(leap));
			date_s14.years <= 12'(YW'(era_s13) * YW'(400) + YW'(yc_s13) - YW'(1900));
		end
	end

	assign date = date_s14;

endmodule

// ===== hw/rtl/epoch_seconds_to_utc_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar: epoch seconds to UTC calendar breakdown
// Fully pipelined converter from seconds since 1970-01-01 UTC to date,
// time of day, weekday, day of year and a US-style daylight-saving flag.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   s_*      | in        | epoch_seconds
//   m_*      | out       | second, minute, hour, day_of_month, month,
//            |           | years_since_1900, weekday, day_of_year, dst_flag
//
// One transfer in per cycle while s_tready is high, one result per transfer;
// the register chain has 14 stages (3 for the day split, 11 for the date).
// Every stage has its own load enable: a stalled output holds its result
// while empty stages upstream keep filling, so s_tready drops only when all
// 14 stages are full. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar #(
	parameter int SECONDS_WIDTH = 36
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [SECONDS_WIDTH-1:0] epoch_seconds, rest zero
	input  logic [((SECONDS_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
	// [25:22] month, [37:26] years_since_1900, [40:38] weekday,
	// [49:41] day_of_year, [50] dst_flag, [55:51] zero
	output logic [eputc_pkg::OUT_TDATA_W-1:0]      m_tdata
);
	import eputc_pkg::*;

	logic [NST:1]             vld_q;
	logic [NST:1]             en;
	logic [SECONDS_WIDTH-17:0] days;
	logic [SOD_W-1:0]         sod;
	hms_t                     hms;
	date_t                    date;

	localparam logic [NST:1] ONES = '1;

	// a stage may load when m_tready is high, or when it or some stage after it is empty
	always_comb begin
		for (int s = 1; s <= NST; s++) begin
			en[s] = m_tready || ((vld_q >> (s - 1)) != (ONES >> (s - 1)));
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int s = 2; s <= NST; s++) begin
				if (en[s]) begin
					vld_q[s] <= vld_q[s-1];
				end
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NST];

	// seconds to days and seconds of the day
	eputc_daysplit #(
		.SECONDS_WIDTH (SECONDS_WIDTH)
	) u_daysplit (
		.clk           (clk),
		.en            (en[FRONT_ST:1]),
		.epoch_seconds (s_tdata[SECONDS_WIDTH-1:0]),
		.days          (days),
		.sod           (sod)
	);

	// time of day
	eputc_tod u_tod (
		.clk (clk),
		.en  (en[NST:FRONT_ST+1]),
		.sod (sod),
		.hms (hms)
	);

	// calendar date
	eputc_civil #(
		.SECONDS_WIDTH (SECONDS_WIDTH)
	) u_civil (
		.clk  (clk),
		.en   (en[NST:FRONT_ST+1]),
		.days (days),
		.date (date)
	);

	// output packing
	assign m_tdata = {(OUT_TDATA_W - OUT_W)'(0), date.dst, date.yday, date.wday,
		date.years, date.month, date.mday, hms.hour, hms.minute, hms.second};

	// back pressure only with a full pipeline
	assert property (@(posedge clk) disable iff (!arst_n) !s_tready |-> (&vld_q))
		else $error("input stalled while a pipeline stage is empty");

	// time of day in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hms.hour < 5'd24 && hms.minute < 6'd60 && hms.second < 6'd60))
		else $error("time of day out of range");

	// date fields in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (date.month <= MON_DEC && date.mday != 5'd0 && date.wday < 3'd7
			&& date.yday < 9'd366))
		else $error("date field out of range");

	// January: day of year follows day of month
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && date.month == MON_JAN) |-> (date.yday == 9'(date.mday) - 9'd1))
		else $error("day of year inconsistent in January");

	// summer months always flagged, winter months never
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((date.month >= MON_APR && date.month <= MON_OCT) ? date.dst
			: ((date.month == MON_MAR || date.month == MON_NOV) || !date.dst)))
		else $error("daylight saving flag wrong for month");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of epoch_seconds_to_utc_calendar
// Drives epoch timestamps over the input stream and checks every calendar
// result, field by field and in order, against a predictor built into the
// bench. A directed table covers the range ends, leap days, century years
// and the March and November daylight-saving edges. Random stamps follow,
// under three idling mixes, with one long output stall that backs the
// pipeline up into its input.
// ----------------------------------------------------------------------------
module tb;
	import eputc_pkg::*;

	localparam int SEC_W          = 36;
	localparam int S_TDATA_W      = ((SEC_W + 7) / 8) * 8;
	localparam longint MAX_STAMP  = (longint'(1) << SEC_W) - 1;
	localparam int DAY_SEC        = 86400;
	localparam int RAND_PER_PHASE = 217;
	localparam int HOLD_CYCLES    = 60;

	// calendar result, laid out as on m_tdata, lowest field last
	typedef struct packed {
		logic        dst;
		logic [8:0]  yday;
		logic [2:0]  wday;
		logic [11:0] years;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_t;

	typedef struct packed {
		logic [SEC_W-1:0] stamp;
		logic             typed;
		cal_t             want;
	} stim_row_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	cal_t calendar_due[$];
	cal_t got_cal;
	cal_t due_cal;
	int   mismatches  = 0;
	int   tx_idle_pct = 27;
	int   rx_idle_pct = 63;
	bit   hold_req    = 1'b0;

	epoch_seconds_to_utc_calendar #(
		.SECONDS_WIDTH(SEC_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// run limit, far above the slowest correct run
	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	// ---- calendar arithmetic ----

	function automatic longint leaps_upto(input longint y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	// days from 1970-01-01 to January 1st of year y
	function automatic longint days_to_jan1(input longint y);
		return 365 * (y - 1970) + leaps_upto(y - 1) - leaps_upto(1969);
	endfunction

	function automatic int month_len(input logic [3:0] mon, input bit leap);
		case (mon)
			MON_FEB:                            return leap ? 29 : 28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
			default:                            return 31;
		endcase
	endfunction

	function automatic bit leap_year(input longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// expected breakdown of one timestamp
	function automatic cal_t utc_breakdown(input logic [SEC_W-1:0] stamp);
		longint     days, sod, yr, yday, first;
		int         prev_sun;
		bit         leap;
		logic [3:0] mon;
		cal_t       r;
		days = longint'(stamp) / DAY_SEC;
		sod  = longint'(stamp) % DAY_SEC;
		yr   = 1970 + days / 366;
		while (days_to_jan1(yr + 1) <= days)
			yr++;
		yday  = days - days_to_jan1(yr);
		leap  = leap_year(yr);
		mon   = MON_JAN;
		first = 0;
		while (mon < MON_DEC && first + month_len(mon, leap) <= yday) begin
			first += month_len(mon, leap);
			mon++;
		end
		r.second = 6'(sod % 60);
		r.minute = 6'((sod / 60) % 60);
		r.hour   = 5'(sod / 3600);
		r.mday   = 5'(yday - first + 1);
		r.month  = mon;
		r.years  = 12'(yr - 1900);
		r.wday   = 3'((days + 4) % 7);
		r.yday   = 9'(yday);
		// US rule: keyed on the Sunday on or before this day
		prev_sun = int'(r.mday) - int'(r.wday);
		case (mon)
			MON_JAN, MON_FEB, MON_DEC: r.dst = 1'b0;
			MON_MAR:                   r.dst = (prev_sun >= 8);
			MON_NOV:                   r.dst = (prev_sun <= 0);
			default:                   r.dst = 1'b1;
		endcase
		return r;
	endfunction

	// random stamp: full range, 32-bit era, or near a month start
	function automatic logic [SEC_W-1:0] random_stamp();
		longint d, s, first;
		int     yr;
		bit     leap;
		logic [3:0] mon;
		case ($urandom_range(9))
			0, 1, 2, 3: return {4'($urandom_range(15)), 32'($urandom)};
			4, 5:       return SEC_W'($urandom);
			default: begin
				yr    = $urandom_range(4146, 1970);
				leap  = leap_year(yr);
				mon   = 4'($urandom_range(11));
				first = 0;
				for (int m = 0; m < mon; m++)
					first += month_len(4'(m), leap);
				d = days_to_jan1(yr) + first + $urandom_range(15) - 1;
				if (d < 0)
					d = 0;
				case ($urandom_range(2))
					0:       s = d * DAY_SEC;
					1:       s = d * DAY_SEC + DAY_SEC - 1;
					default: s = d * DAY_SEC + $urandom_range(DAY_SEC - 1);
				endcase
				if (s > MAX_STAMP)
					s = MAX_STAMP;
				return s[SEC_W-1:0];
			end
		endcase
	endfunction

	// ---- stimulus ----

	localparam stim_row_t DIR_ROWS [22] = '{
		// epoch start, Thursday
		'{36'd0, 1'b1, '{dst: 1'b0, yday: 9'd0, wday: 3'd4, years: 12'd70,
			month: MON_JAN, mday: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0}},
		// last second of the first day
		'{36'd86399, 1'b1, '{dst: 1'b0, yday: 9'd0, wday: 3'd4, years: 12'd70,
			month: MON_JAN, mday: 5'd1, hour: 5'd23, minute: 6'd59, second: 6'd59}},
		// second day, Friday
		'{36'd86400, 1'b1, '{dst: 1'b0, yday: 9'd1, wday: 3'd5, years: 12'd70,
			month: MON_JAN, mday: 5'd2, hour: 5'd0, minute: 6'd0, second: 6'd0}},
		'{36'hF_FFFF_FFFF, 1'b0, '0},
		'{36'h8_0000_0000, 1'b0, '0},
		'{36'h1_0000_0000, 1'b0, '0},
		'{36'h5_5555_5555, 1'b0, '0},
		'{36'hA_AAAA_AAAA, 1'b0, '0},
		'{36'h7_FFFF_FFFF, 1'b0, '0},
		// leap day and day 365 of a 400-year leap year
		'{36'd951782400, 1'b0, '0},
		'{36'd978220800, 1'b0, '0},
		// century non-leap: Feb 28 then Mar 1
		'{36'd4107456000, 1'b0, '0},
		'{36'd4107542400, 1'b0, '0},
		// March: Saturday before, then second Sunday
		'{36'd1709942400, 1'b0, '0},
		'{36'd1710028800, 1'b0, '0},
		// March with the 8th on a Sunday, and the Saturday before it
		'{36'd1772841600, 1'b0, '0},
		'{36'd1772928000, 1'b0, '0},
		// November: Friday 1st, Saturday 2nd, first Sunday
		'{36'd1730419200, 1'b0, '0},
		'{36'd1730505600, 1'b0, '0},
		'{36'd1730592000, 1'b0, '0},
		// April 1st and December 31st
		'{36'd1711929600, 1'b0, '0},
		'{36'd1703980800, 1'b0, '0}
	};

	// offer one stamp until a transfer takes it, then log the expectation
	task automatic send_stamp(input logic [SEC_W-1:0] stamp, input logic typed,
			input cal_t typed_want);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(stamp);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		calendar_due.push_back(typed ? typed_want : utc_breakdown(stamp));
	endtask

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			send_stamp(DIR_ROWS[i].stamp, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct = 63;
				end
				1: begin
					tx_idle_pct = 63;
					rx_idle_pct = 27;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					hold_req    = 1'b1;
				end
			endcase
			repeat (RAND_PER_PHASE)
				send_stamp(random_stamp(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain, then let any stray result show up
		while (calendar_due.size() != 0)
			@(posedge clk);
		repeat (NST + 8) @(posedge clk);

		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// ---- output side ----

	// random backpressure, plus one long hold while the input keeps pushing
	initial begin
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
			@(posedge clk);
		end
	end

	// compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_cal = cal_t'(m_tdata[OUT_W-1:0]);
			if (calendar_due.size() == 0) begin
				report_mismatch("unexpected result, second", got_cal.second, 0);
			end else begin
				due_cal = calendar_due.pop_front();
				if (got_cal.second != due_cal.second)
					report_mismatch("second", got_cal.second, due_cal.second);
				if (got_cal.minute != due_cal.minute)
					report_mismatch("minute", got_cal.minute, due_cal.minute);
				if (got_cal.hour != due_cal.hour)
					report_mismatch("hour", got_cal.hour, due_cal.hour);
				if (got_cal.mday != due_cal.mday)
					report_mismatch("day_of_month", got_cal.mday, due_cal.mday);
				if (got_cal.month != due_cal.month)
					report_mismatch("month", got_cal.month, due_cal.month);
				if (got_cal.years != due_cal.years)
					report_mismatch("years_since_1900", got_cal.years, due_cal.years);
				if (got_cal.wday != due_cal.wday)
					report_mismatch("weekday", got_cal.wday, due_cal.wday);
				if (got_cal.yday != due_cal.yday)
					report_mismatch("day_of_year", got_cal.yday, due_cal.yday);
				if (got_cal.dst != due_cal.dst)
					report_mismatch("dst_flag", got_cal.dst, due_cal.dst);
			end
		end
	end

endmodule

// ===== files.f =====
hw/rtl/eputc_pkg.sv
hw/rtl/eputc_daysplit.sv
hw/rtl/eputc_tod.sv
hw/rtl/eputc_civil.sv
hw/rtl/epoch_seconds_to_utc_calendar.sv
test/tb.sv
